>>> hw/rtl/cbez_pkg.sv
`default_nettype none

package cbez_pkg;

   // Field widths
   localparam int COORD_WIDTH   = 16;
   localparam int FRACTION_BITS = 16;
   localparam int STEP_WIDTH    = 10;
   localparam int RESULT_WIDTH  = 32;

   localparam int NUM_AXES   = 3;
   localparam int NUM_POINTS = 4;

   // Derived widths
   localparam int STEP_SQ_WIDTH = 2 * STEP_WIDTH;          // i^2, m^2, n^2
   localparam int STEP_X3_WIDTH = STEP_WIDTH + 2;          // 3*i, 3*m
   localparam int W_WIDTH       = 3 * STEP_WIDTH;          // weights, n^3, remainder
   localparam int PROD_WIDTH    = W_WIDTH + COORD_WIDTH;   // weighted sum (exact)
   localparam int QUO_WIDTH     = COORD_WIDTH + FRACTION_BITS;
   localparam int DIV_WIDTH     = W_WIDTH + QUO_WIDTH;     // dividend
   localparam int SAT_WIDTH     = QUO_WIDTH + RESULT_WIDTH;

   localparam int AXIS_X = 0;
   localparam int AXIS_Y = 1;
   localparam int AXIS_Z = 2;

   // Register map
   localparam int CSR_INDEX_WIDTH = 2;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_START_X = 2'd0;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_START_Y = 2'd1;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_START_Z = 2'd2;

   typedef logic signed [COORD_WIDTH-1:0]  coord_type;
   typedef logic signed [RESULT_WIDTH-1:0] result_type;
   typedef logic        [STEP_WIDTH-1:0]   step_type;

   localparam coord_type START_X_RESET = coord_type'(0);
   localparam coord_type START_Y_RESET = coord_type'(12);
   localparam coord_type START_Z_RESET = coord_type'(-20);

   typedef logic [NUM_AXES-1:0][COORD_WIDTH-1:0] start_set_type;
   // offset-binary control points: [axis][point]
   typedef logic [NUM_AXES-1:0][NUM_POINTS-1:0][COORD_WIDTH-1:0] ctrl_all_type;

   typedef struct packed {
      coord_type ctrl_a_x;
      coord_type ctrl_a_y;
      coord_type ctrl_a_z;
      coord_type ctrl_b_x;
      coord_type ctrl_b_y;
      coord_type ctrl_b_z;
      coord_type end_x;
      coord_type end_y;
      coord_type end_z;
      step_type  step_index;
      step_type  step_count;
   } req_type;

   typedef struct packed {
      result_type point_x;
      result_type point_y;
      result_type point_z;
      logic       clamped;
   } rsp_type;

   // weights stage -> blend stage
   typedef struct packed {
      logic [NUM_POINTS-1:0][W_WIDTH-1:0] weight;
      logic [W_WIDTH-1:0]                 den;
      ctrl_all_type                       pts;
      logic                               clamped;
   } wt_type;

   // one slot of the divider pipe; bits holds dividend bits still to go at
   // the top and quotient bits already found at the bottom
   typedef struct packed {
      logic [NUM_AXES-1:0][W_WIDTH-1:0]   rem;
      logic [NUM_AXES-1:0][QUO_WIDTH-1:0] bits;
      logic [W_WIDTH-1:0]                 den;
      logic                               clamped;
   } div_type;

   function automatic logic [COORD_WIDTH-1:0] to_offset(input coord_type c);
      return {~c[COORD_WIDTH-1], c[COORD_WIDTH-2:0]};
   endfunction

   // quotient is offset binary; remove the offset and saturate
   function automatic result_type to_result(input logic [QUO_WIDTH-1:0] q);
      logic signed [QUO_WIDTH-1:0] v;
      logic signed [SAT_WIDTH-1:0] ext;
      logic signed [SAT_WIDTH-1:0] max_val;
      logic signed [SAT_WIDTH-1:0] min_val;
      v       = {~q[QUO_WIDTH-1], q[QUO_WIDTH-2:0]};
      ext     = {{RESULT_WIDTH{v[QUO_WIDTH-1]}}, v};
      max_val = {{(QUO_WIDTH+1){1'b0}}, {(RESULT_WIDTH-1){1'b1}}};
      min_val = {{(QUO_WIDTH+1){1'b1}}, {(RESULT_WIDTH-1){1'b0}}};
      if (ext > max_val) begin
         return max_val[RESULT_WIDTH-1:0];
      end else if (ext < min_val) begin
         return min_val[RESULT_WIDTH-1:0];
      end
      return ext[RESULT_WIDTH-1:0];
   endfunction

endpackage

`default_nettype wire

>>> hw/rtl/cbez_weights.sv
`default_nettype none

// Step clamp, then Bernstein weights (n-i)^3, 3i(n-i)^2, 3i^2(n-i), i^3 and n^3.
module cbez_weights (
   input  wire logic                   clock,
   input  wire logic                   reset,
   input  wire logic                   en,
   input  wire logic                   in_valid,
   input  wire cbez_pkg::req_type      in_word,
   input  wire cbez_pkg::start_set_type start_pt,
   output logic                        out_valid,
   output cbez_pkg::wt_type            out_word
);

   localparam int SW  = cbez_pkg::STEP_WIDTH;
   localparam int SQW = cbez_pkg::STEP_SQ_WIDTH;
   localparam int X3W = cbez_pkg::STEP_X3_WIDTH;
   localparam int WW  = cbez_pkg::W_WIDTH;

   // stage A: clamp
   logic                       a_valid_ff;
   logic [SW-1:0]              a_n_ff, a_i_ff, a_m_ff;
   logic                       a_clamped_ff;
   cbez_pkg::ctrl_all_type     a_pts_ff;
   logic [SW-1:0]              a_n_in, a_i_in, a_m_in;
   logic                       a_clamped_in;
   cbez_pkg::ctrl_all_type     a_pts_in;

   // stage B: squares and triples
   logic                       b_valid_ff;
   logic [SW-1:0]              b_n_ff, b_i_ff, b_m_ff;
   logic [SQW-1:0]             b_n2_ff, b_i2_ff, b_m2_ff;
   logic [X3W-1:0]             b_i3_ff, b_m3_ff;
   logic                       b_clamped_ff;
   cbez_pkg::ctrl_all_type     b_pts_ff;
   logic [SQW-1:0]             b_n2_in, b_i2_in, b_m2_in;
   logic [X3W-1:0]             b_i3_in, b_m3_in;

   // stage C: cubes
   logic                       c_valid_ff;
   cbez_pkg::wt_type           c_word_ff;
   cbez_pkg::wt_type           c_word_in;
   logic [WW+1:0]              w1_full, w2_full;

   always_comb begin
      a_n_in       = (in_word.step_count == '0) ? {{(SW-1){1'b0}}, 1'b1} : in_word.step_count;
      a_clamped_in = in_word.step_index > a_n_in;
      a_i_in       = a_clamped_in ? a_n_in : in_word.step_index;
      a_m_in       = a_n_in - a_i_in;

      a_pts_in[cbez_pkg::AXIS_X][0] = cbez_pkg::to_offset(start_pt[cbez_pkg::AXIS_X]);
      a_pts_in[cbez_pkg::AXIS_X][1] = cbez_pkg::to_offset(in_word.ctrl_a_x);
      a_pts_in[cbez_pkg::AXIS_X][2] = cbez_pkg::to_offset(in_word.ctrl_b_x);
      a_pts_in[cbez_pkg::AXIS_X][3] = cbez_pkg::to_offset(in_word.end_x);
      a_pts_in[cbez_pkg::AXIS_Y][0] = cbez_pkg::to_offset(start_pt[cbez_pkg::AXIS_Y]);
      a_pts_in[cbez_pkg::AXIS_Y][1] = cbez_pkg::to_offset(in_word.ctrl_a_y);
      a_pts_in[cbez_pkg::AXIS_Y][2] = cbez_pkg::to_offset(in_word.ctrl_b_y);
      a_pts_in[cbez_pkg::AXIS_Y][3] = cbez_pkg::to_offset(in_word.end_y);
      a_pts_in[cbez_pkg::AXIS_Z][0] = cbez_pkg::to_offset(start_pt[cbez_pkg::AXIS_Z]);
      a_pts_in[cbez_pkg::AXIS_Z][1] = cbez_pkg::to_offset(in_word.ctrl_a_z);
      a_pts_in[cbez_pkg::AXIS_Z][2] = cbez_pkg::to_offset(in_word.ctrl_b_z);
      a_pts_in[cbez_pkg::AXIS_Z][3] = cbez_pkg::to_offset(in_word.end_z);
   end

   always_comb begin
      b_n2_in = {{SW{1'b0}}, a_n_ff} * {{SW{1'b0}}, a_n_ff};
      b_i2_in = {{SW{1'b0}}, a_i_ff} * {{SW{1'b0}}, a_i_ff};
      b_m2_in = {{SW{1'b0}}, a_m_ff} * {{SW{1'b0}}, a_m_ff};
      b_i3_in = {2'b00, a_i_ff} + {1'b0, a_i_ff, 1'b0};
      b_m3_in = {2'b00, a_m_ff} + {1'b0, a_m_ff, 1'b0};
   end

   // every weight is at most n^3, so truncating the triple products is exact
   always_comb begin
      w1_full = {{(SW+2){1'b0}}, b_m2_ff} * {{SQW{1'b0}}, b_i3_ff};
      w2_full = {{(SW+2){1'b0}}, b_i2_ff} * {{SQW{1'b0}}, b_m3_ff};
      c_word_in.weight[0] = {{SW{1'b0}}, b_m2_ff} * {{SQW{1'b0}}, b_m_ff};
      c_word_in.weight[1] = w1_full[WW-1:0];
      c_word_in.weight[2] = w2_full[WW-1:0];
      c_word_in.weight[3] = {{SW{1'b0}}, b_i2_ff} * {{SQW{1'b0}}, b_i_ff};
      c_word_in.den       = {{SW{1'b0}}, b_n2_ff} * {{SQW{1'b0}}, b_n_ff};
      c_word_in.pts       = b_pts_ff;
      c_word_in.clamped   = b_clamped_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         a_valid_ff <= 1'b0;
         b_valid_ff <= 1'b0;
         c_valid_ff <= 1'b0;
      end else if (en) begin
         a_valid_ff <= in_valid;
         b_valid_ff <= a_valid_ff;
         c_valid_ff <= b_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         a_n_ff       <= a_n_in;
         a_i_ff       <= a_i_in;
         a_m_ff       <= a_m_in;
         a_clamped_ff <= a_clamped_in;
         a_pts_ff     <= a_pts_in;

         b_n_ff       <= a_n_ff;
         b_i_ff       <= a_i_ff;
         b_m_ff       <= a_m_ff;
         b_n2_ff      <= b_n2_in;
         b_i2_ff      <= b_i2_in;
         b_m2_ff      <= b_m2_in;
         b_i3_ff      <= b_i3_in;
         b_m3_ff      <= b_m3_in;
         b_clamped_ff <= a_clamped_ff;
         b_pts_ff     <= a_pts_ff;

         c_word_ff    <= c_word_in;
      end
   end

   assign out_valid = c_valid_ff;
   assign out_word  = c_word_ff;

endmodule

`default_nettype wire

>>> hw/rtl/cbez_blend.sv
`default_nettype none

// Weighted sum per axis, then scale and add half the divisor for rounding.
module cbez_blend (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              en,
   input  wire logic              in_valid,
   input  wire cbez_pkg::wt_type  in_word,
   output logic                   out_valid,
   output cbez_pkg::div_type      out_word
);

   localparam int NA  = cbez_pkg::NUM_AXES;
   localparam int NP  = cbez_pkg::NUM_POINTS;
   localparam int CW  = cbez_pkg::COORD_WIDTH;
   localparam int WW  = cbez_pkg::W_WIDTH;
   localparam int PW  = cbez_pkg::PROD_WIDTH;
   localparam int QW  = cbez_pkg::QUO_WIDTH;
   localparam int DW  = cbez_pkg::DIV_WIDTH;
   localparam int FB  = cbez_pkg::FRACTION_BITS;

   // stage D: products
   logic                          d_valid_ff;
   logic [NA-1:0][NP-1:0][PW-1:0] d_prod_ff, d_prod_in;
   logic [WW-1:0]                 d_den_ff;
   logic                          d_clamped_ff;

   // stage E: sums (exact in PW bits since the weights add up to n^3)
   logic                          e_valid_ff;
   logic [NA-1:0][PW-1:0]         e_acc_ff, e_acc_in;
   logic [WW-1:0]                 e_den_ff;
   logic                          e_clamped_ff;

   // stage F: dividend split into first remainder and remaining bits
   logic                          f_valid_ff;
   cbez_pkg::div_type             f_word_ff, f_word_in;
   logic [NA-1:0][DW-1:0]         dividend;

   always_comb begin
      for (int a = 0; a < NA; a++) begin
         for (int k = 0; k < NP; k++) begin
            d_prod_in[a][k] = {{CW{1'b0}}, in_word.weight[k]} *
                              {{WW{1'b0}}, in_word.pts[a][k]};
         end
      end
   end

   always_comb begin
      for (int a = 0; a < NA; a++) begin
         e_acc_in[a] = (d_prod_ff[a][0] + d_prod_ff[a][1]) +
                       (d_prod_ff[a][2] + d_prod_ff[a][3]);
      end
   end

   always_comb begin
      for (int a = 0; a < NA; a++) begin
         dividend[a] = {e_acc_ff[a], {FB{1'b0}}} + {{(QW+1){1'b0}}, e_den_ff[WW-1:1]};
         f_word_in.rem[a]  = dividend[a][DW-1:QW];
         f_word_in.bits[a] = dividend[a][QW-1:0];
      end
      f_word_in.den     = e_den_ff;
      f_word_in.clamped = e_clamped_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         d_valid_ff <= 1'b0;
         e_valid_ff <= 1'b0;
         f_valid_ff <= 1'b0;
      end else if (en) begin
         d_valid_ff <= in_valid;
         e_valid_ff <= d_valid_ff;
         f_valid_ff <= e_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         d_prod_ff    <= d_prod_in;
         d_den_ff     <= in_word.den;
         d_clamped_ff <= in_word.clamped;
         e_acc_ff     <= e_acc_in;
         e_den_ff     <= d_den_ff;
         e_clamped_ff <= d_clamped_ff;
         f_word_ff    <= f_word_in;
      end
   end

   assign out_valid = f_valid_ff;
   assign out_word  = f_word_ff;

endmodule

`default_nettype wire

>>> hw/rtl/cbez_div_stage.sv
`default_nettype none

// One restoring-division step on all three axes: one quotient bit each.
module cbez_div_stage (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               en,
   input  wire logic               in_valid,
   input  wire cbez_pkg::div_type  in_word,
   output logic                    out_valid,
   output cbez_pkg::div_type       out_word
);

   localparam int NA = cbez_pkg::NUM_AXES;
   localparam int WW = cbez_pkg::W_WIDTH;
   localparam int QW = cbez_pkg::QUO_WIDTH;

   logic                 valid_ff;
   cbez_pkg::div_type    word_ff, word_in;
   logic [NA-1:0][WW:0]  trial;
   logic [NA-1:0][WW:0]  diff;
   logic [NA-1:0]        fits;

   always_comb begin
      for (int a = 0; a < NA; a++) begin
         trial[a] = {in_word.rem[a], in_word.bits[a][QW-1]};
         diff[a]  = trial[a] - {1'b0, in_word.den};
         fits[a]  = trial[a] >= {1'b0, in_word.den};
         word_in.rem[a]  = fits[a] ? diff[a][WW-1:0] : trial[a][WW-1:0];
         word_in.bits[a] = {in_word.bits[a][QW-2:0], fits[a]};
      end
      word_in.den     = in_word.den;
      word_in.clamped = in_word.clamped;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (en) begin
         valid_ff <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         word_ff <= word_in;
      end
   end

   assign out_valid = valid_ff;
   assign out_word  = word_ff;

endmodule

`default_nettype wire

>>> hw/rtl/cubic_bezier_point_eval.sv
`default_nettype none

// Cubic Bezier point evaluator. Each request word carries the two inner
// control points, the end point and a step i of n; the start point comes from
// the three start registers (reset values 0, 12, -20). The response word holds
// the point B(i/n) per axis in signed Q16.16, computed exactly from the
// Bernstein form and rounded to nearest with ties toward +infinity; a step
// count of 0 acts as 1, and a step above the count is taken as the count with
// the clamped flag set. The pipeline takes one word per clock while it is not
// stalled: 3 stages build the weights, 3 form the weighted sums and dividend,
// 32 divider stages find one quotient bit each, and one output register holds
// the response. The pipe only stalls when the output register is full and not
// taken and a result is about to arrive, so bubbles are squeezed out while the
// consumer holds off. Start registers are to be written only while the block is
// empty; csr_ready is always high.
module cubic_bezier_point_eval (
   input  wire logic                                   clock,
   input  wire logic                                   reset,

   input  wire logic                                   req_valid,
   output logic                                        req_ready,
   input  wire cbez_pkg::req_type                      req_word,

   output logic                                        rsp_valid,
   input  wire logic                                   rsp_ready,
   output cbez_pkg::rsp_type                           rsp_word,

   input  wire logic                                   csr_valid,
   output logic                                        csr_ready,
   input  wire logic [cbez_pkg::CSR_INDEX_WIDTH-1:0]   csr_index,
   input  wire cbez_pkg::coord_type                    csr_data
);

   localparam int QW = cbez_pkg::QUO_WIDTH;

   // start point registers
   cbez_pkg::start_set_type start_ff;

   // pipeline advance
   logic pipe_en;

   // weights -> blend
   logic              wt_valid;
   cbez_pkg::wt_type  wt_word;

   // divider chain: slot 0 from blend, slot QW holds finished quotients
   logic [QW:0]       div_valid;
   cbez_pkg::div_type div_word [0:QW];

   // output register
   logic              rsp_valid_ff;
   cbez_pkg::rsp_type rsp_word_ff, rsp_word_in;
   logic              rsp_load;

   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         start_ff[cbez_pkg::AXIS_X] <= cbez_pkg::START_X_RESET;
         start_ff[cbez_pkg::AXIS_Y] <= cbez_pkg::START_Y_RESET;
         start_ff[cbez_pkg::AXIS_Z] <= cbez_pkg::START_Z_RESET;
      end else if (csr_valid && csr_ready) begin
         case (csr_index)
            cbez_pkg::CSR_START_X: start_ff[cbez_pkg::AXIS_X] <= csr_data;
            cbez_pkg::CSR_START_Y: start_ff[cbez_pkg::AXIS_Y] <= csr_data;
            cbez_pkg::CSR_START_Z: start_ff[cbez_pkg::AXIS_Z] <= csr_data;
            default: ;  // unmapped index, write dropped
         endcase
      end
   end

   // Everything shifts unless a finished result would land on a full,
   // stalled output register.
   assign pipe_en   = !rsp_valid_ff || rsp_ready || !div_valid[QW];
   assign req_ready = pipe_en;

   cbez_weights u_weights (
      .clock     (clock),
      .reset     (reset),
      .en        (pipe_en),
      .in_valid  (req_valid),
      .in_word   (req_word),
      .start_pt  (start_ff),
      .out_valid (wt_valid),
      .out_word  (wt_word)
   );

   cbez_blend u_blend (
      .clock     (clock),
      .reset     (reset),
      .en        (pipe_en),
      .in_valid  (wt_valid),
      .in_word   (wt_word),
      .out_valid (div_valid[0]),
      .out_word  (div_word[0])
   );

   for (genvar g = 0; g < QW; g++) begin : g_div
      cbez_div_stage u_stage (
         .clock     (clock),
         .reset     (reset),
         .en        (pipe_en),
         .in_valid  (div_valid[g]),
         .in_word   (div_word[g]),
         .out_valid (div_valid[g+1]),
         .out_word  (div_word[g+1])
      );
   end

   // after the last step bits holds the offset-binary quotient
   always_comb begin
      rsp_word_in.point_x = cbez_pkg::to_result(div_word[QW].bits[cbez_pkg::AXIS_X]);
      rsp_word_in.point_y = cbez_pkg::to_result(div_word[QW].bits[cbez_pkg::AXIS_Y]);
      rsp_word_in.point_z = cbez_pkg::to_result(div_word[QW].bits[cbez_pkg::AXIS_Z]);
      rsp_word_in.clamped = div_word[QW].clamped;
   end

   assign rsp_load = div_valid[QW] && (!rsp_valid_ff || rsp_ready);

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (!rsp_valid_ff || rsp_ready) begin
         rsp_valid_ff <= div_valid[QW];
      end
   end

   always_ff @(posedge clock) begin
      if (rsp_load) begin
         rsp_word_ff <= rsp_word_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_word  = rsp_word_ff;

`ifndef SYNTHESIS
   // the divider keeps every partial remainder below the divisor
   a_rem_below_den: assert property (@(posedge clock) disable iff (reset)
      div_valid[QW] |->
         (div_word[QW].rem[cbez_pkg::AXIS_X] < div_word[QW].den) &&
         (div_word[QW].rem[cbez_pkg::AXIS_Y] < div_word[QW].den) &&
         (div_word[QW].rem[cbez_pkg::AXIS_Z] < div_word[QW].den))
      else $error("divider remainder not below divisor");

   // a finished result facing a stalled full output must freeze the pipe
   a_stall_holds_pipe: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && !rsp_ready && div_valid[QW]) |-> !req_ready)
      else $error("pipeline advanced into a stalled output");

   // a stalled result at the tail stays put for the next cycle
   a_tail_kept: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && !rsp_ready && div_valid[QW]) |=> div_valid[QW])
      else $error("result lost at pipeline tail");

   a_reset_empty: assert property (@(posedge clock)
      reset |=> !rsp_valid_ff)
      else $error("response valid right after reset");
`endif

endmodule

`default_nettype wire
